@@ sv/glob_wildcard_matcher_assert.svh @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher assertion macros
// Clocked assertion forms used by the matcher top level; clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define GWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glob matcher check failed");

// Next-cycle implication, checked out of reset
`define GWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glob matcher check failed");

`endif

@@ sv/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Request codes, request, queue status and back-end state types, queue sizing, pattern character constants.
// ----------------------------------------------------------------------------
package gwm_pkg;

    // Request kind codes as seen on the kind port
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PAT   = 2'd1;
    localparam logic [1:0] KIND_STR   = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Pattern wildcards
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PAT,
        OP_STR,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        B_RUN,
        B_ISSUE,
        B_MCMP,
        B_TCMP
    } back_state_t;

endpackage

@@ sv/glob_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Loads a glob pattern and a byte string, then reports whether they match.
// ----------------------------------------------------------------------------
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------
//   request   | start high, busy low| kind[1:0], char_byte[7:0]
//   result    | strobe, one cycle   | matched, overflow
//
// Clear and load requests are taken one per cycle while busy is low, executed
// one per cycle while no match runs. An end-of-string request holds the back
// end for its walk, each step issuing the store reads, then comparing; a match
// closes in the issue state, and a dropped byte skips the walk. The strobe is
// registered. The backtracking walk makes at most about (pattern+1)*(string+1)
// steps, as each store has one read port with registered data and each step
// compares once. A four-deep queue lets requests keep arriving during a match.
// Reset clears lengths, overflow flags, queue and sequencer; store contents
// stay undefined and need no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_assert.svh"

module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = 64,
    parameter int STRING_MAX  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] char_byte,
    output logic       strobe,
    output logic       matched,
    output logic       overflow
);

    gwm_pkg::q_stat_t q_stat;
    gwm_pkg::req_t    push_req;
    gwm_pkg::req_t    head_req;
    logic             push;
    logic             pop;
    logic             matching;

    // Front: take and decode requests
    gwm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .char_byte (char_byte),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push),
        .push_req  (push_req)
    );

    // Request queue
    gwm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .q_stat   (q_stat)
    );

    // Back: stores and match sequencer
    gwm_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .STRING_MAX  (STRING_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_req (head_req),
        .pop      (pop),
        .matching (matching),
        .strobe   (strobe),
        .matched  (matched),
        .overflow (overflow)
    );

    // Checks
    `GWM_ASSERT_NOW(a_ovf_kills_match, strobe && overflow, !matched)
    `GWM_ASSERT_NOW(a_no_result_mid_match, matching, !strobe)
    `GWM_ASSERT_NEXT(a_full_queue_no_pop_loss, q_stat.full && !pop, q_stat.full || push)

endmodule

@@ sv/gwm_front.sv @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher front end
// Takes requests, decodes the kind code and holds one request for the queue.
// ----------------------------------------------------------------------------
module gwm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       kind,
    input  logic [7:0]       char_byte,
    input  gwm_pkg::q_stat_t q_stat,
    output logic             busy,
    output logic             push,
    output gwm_pkg::req_t    push_req
);

    logic          valid_reg;
    logic          valid_next;
    gwm_pkg::req_t req_reg;
    gwm_pkg::req_t req_next;
    gwm_pkg::req_t dec_req;
    logic          accept;

    // Decode the kind code
    always_comb
    begin
        dec_req.data = char_byte;
        unique case (kind)
            gwm_pkg::KIND_CLEAR: dec_req.op = gwm_pkg::OP_CLEAR;
            gwm_pkg::KIND_PAT:   dec_req.op = gwm_pkg::OP_PAT;
            gwm_pkg::KIND_STR:   dec_req.op = gwm_pkg::OP_STR;
            default:             dec_req.op = gwm_pkg::OP_END;
        endcase
    end

    // Holding stage: stalls only while the queue is full
    assign busy     = valid_reg && q_stat.full;
    assign accept   = start && !busy;
    assign push     = valid_reg && !q_stat.full;
    assign push_req = req_reg;

    always_comb
    begin
        valid_next = accept || (valid_reg && !push);
        req_next   = accept ? dec_req : req_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

@@ sv/gwm_queue.sv @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher request queue
// Short FIFO that lets the front keep taking requests while a match runs.
// ----------------------------------------------------------------------------
module gwm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gwm_pkg::req_t    push_req,
    input  logic             pop,
    output gwm_pkg::req_t    head_req,
    output gwm_pkg::q_stat_t q_stat
);

    gwm_pkg::req_t                entry_reg [gwm_pkg::QUEUE_DEPTH];
    logic [gwm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [gwm_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [gwm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [gwm_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [gwm_pkg::QCNT_W-1:0]   count_reg;
    logic [gwm_pkg::QCNT_W-1:0]   count_next;

    assign q_stat.full  = (count_reg == gwm_pkg::QCNT_W'(gwm_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_req     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ sv/gwm_back.sv @@
// ----------------------------------------------------------------------------
// Glob wildcard matcher back end
// Stores pattern and string bytes and runs the backtracking glob match.
// ----------------------------------------------------------------------------
module gwm_back #(
    parameter int PATTERN_MAX = 64,
    parameter int STRING_MAX  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gwm_pkg::q_stat_t q_stat,
    input  gwm_pkg::req_t    head_req,
    output logic             pop,
    output logic             matching,
    output logic             strobe,
    output logic             matched,
    output logic             overflow
);

    localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int SAW = (STRING_MAX > 1) ? $clog2(STRING_MAX) : 1;
    localparam int SLW = $clog2(STRING_MAX + 1);

    // Byte stores
    logic [7:0] pat_mem [PATTERN_MAX];
    logic [7:0] str_mem [STRING_MAX];
    logic [7:0] pat_rd_reg;
    logic [7:0] str_rd_reg;
    logic       pat_we;
    logic       str_we;

    gwm_pkg::back_state_t state_reg;
    gwm_pkg::back_state_t state_next;
    logic [PLW-1:0] plen_reg, plen_next;
    logic [SLW-1:0] slen_reg, slen_next;
    logic           pdrop_reg, pdrop_next;
    logic           sdrop_reg, sdrop_next;
    logic [PLW-1:0] p_reg, p_next;
    logic [SLW-1:0] s_reg, s_next;
    logic [PLW-1:0] star_reg, star_next;
    logic [SLW-1:0] resume_reg, resume_next;
    logic           have_star_reg, have_star_next;
    logic           strobe_reg, strobe_next;
    logic           matched_reg, matched_next;
    logic           overflow_reg, overflow_next;
    logic           p_ok;

    assign pop      = (state_reg == gwm_pkg::B_RUN) && !q_stat.empty;
    assign matching = (state_reg != gwm_pkg::B_RUN);
    assign strobe   = strobe_reg;
    assign matched  = matched_reg;
    assign overflow = overflow_reg;
    assign p_ok     = (p_reg < plen_reg);

    // Request execution and match sequencer
    always_comb
    begin
        state_next     = state_reg;
        plen_next      = plen_reg;
        slen_next      = slen_reg;
        pdrop_next     = pdrop_reg;
        sdrop_next     = sdrop_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        star_next      = star_reg;
        resume_next    = resume_reg;
        have_star_next = have_star_reg;
        strobe_next    = 1'b0;
        matched_next   = matched_reg;
        overflow_next  = overflow_reg;
        pat_we         = 1'b0;
        str_we         = 1'b0;

        unique case (state_reg)
            gwm_pkg::B_RUN:
            begin
                if (pop)
                begin
                    unique case (head_req.op)
                        gwm_pkg::OP_CLEAR:
                        begin
                            plen_next  = '0;
                            pdrop_next = 1'b0;
                        end
                        gwm_pkg::OP_PAT:
                        begin
                            if (plen_reg < PLW'(PATTERN_MAX))
                            begin
                                pat_we    = 1'b1;
                                plen_next = plen_reg + 1'b1;
                            end
                            else
                            begin
                                pdrop_next = 1'b1;
                            end
                        end
                        gwm_pkg::OP_STR:
                        begin
                            if (slen_reg < SLW'(STRING_MAX))
                            begin
                                str_we    = 1'b1;
                                slen_next = slen_reg + 1'b1;
                            end
                            else
                            begin
                                sdrop_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (pdrop_reg || sdrop_reg)
                            begin
                                strobe_next   = 1'b1;
                                matched_next  = 1'b0;
                                overflow_next = 1'b1;
                                slen_next     = '0;
                                sdrop_next    = 1'b0;
                            end
                            else
                            begin
                                p_next         = '0;
                                s_next         = '0;
                                star_next      = '0;
                                resume_next    = '0;
                                have_star_next = 1'b0;
                                state_next     = gwm_pkg::B_ISSUE;
                            end
                        end
                    endcase
                end
            end

            // Store reads at p and s are in flight this cycle
            gwm_pkg::B_ISSUE:
            begin
                if (s_reg < slen_reg)
                begin
                    state_next = gwm_pkg::B_MCMP;
                end
                else if (p_ok)
                begin
                    state_next = gwm_pkg::B_TCMP;
                end
                else
                begin
                    strobe_next   = 1'b1;
                    matched_next  = 1'b1;
                    overflow_next = 1'b0;
                    slen_next     = '0;
                    sdrop_next    = 1'b0;
                    state_next    = gwm_pkg::B_RUN;
                end
            end

            // One step of the main walk
            gwm_pkg::B_MCMP:
            begin
                state_next = gwm_pkg::B_ISSUE;
                if (p_ok && pat_rd_reg == gwm_pkg::CHAR_STAR)
                begin
                    have_star_next = 1'b1;
                    star_next      = p_reg;
                    resume_next    = s_reg;
                    p_next         = p_reg + 1'b1;
                end
                else if (p_ok && (pat_rd_reg == gwm_pkg::CHAR_QMARK ||
                                  pat_rd_reg == str_rd_reg))
                begin
                    s_next = s_reg + 1'b1;
                    p_next = p_reg + 1'b1;
                end
                else if (have_star_reg)
                begin
                    p_next      = star_reg + 1'b1;
                    resume_next = resume_reg + 1'b1;
                    s_next      = resume_reg + 1'b1;
                end
                else
                begin
                    strobe_next   = 1'b1;
                    matched_next  = 1'b0;
                    overflow_next = 1'b0;
                    slen_next     = '0;
                    sdrop_next    = 1'b0;
                    state_next    = gwm_pkg::B_RUN;
                end
            end

            // Trailing pattern must be all stars
            default:
            begin
                if (pat_rd_reg == gwm_pkg::CHAR_STAR)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = gwm_pkg::B_ISSUE;
                end
                else
                begin
                    strobe_next   = 1'b1;
                    matched_next  = 1'b0;
                    overflow_next = 1'b0;
                    slen_next     = '0;
                    sdrop_next    = 1'b0;
                    state_next    = gwm_pkg::B_RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwm_pkg::B_RUN;
            plen_reg      <= '0;
            slen_reg      <= '0;
            pdrop_reg     <= 1'b0;
            sdrop_reg     <= 1'b0;
            p_reg         <= '0;
            s_reg         <= '0;
            star_reg      <= '0;
            resume_reg    <= '0;
            have_star_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            slen_reg      <= slen_next;
            pdrop_reg     <= pdrop_next;
            sdrop_reg     <= sdrop_next;
            p_reg         <= p_next;
            s_reg         <= s_next;
            star_reg      <= star_next;
            resume_reg    <= resume_next;
            have_star_reg <= have_star_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        matched_reg  <= matched_next;
        overflow_reg <= overflow_next;
    end

    // Pattern store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[plen_reg[PAW-1:0]] <= head_req.data;
        end
        pat_rd_reg <= pat_mem[p_reg[PAW-1:0]];
    end

    // String store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (str_we)
        begin
            str_mem[slen_reg[SAW-1:0]] <= head_req.data;
        end
        str_rd_reg <= str_mem[s_reg[SAW-1:0]];
    end

endmodule
